>>> hdl/deq_pkg.sv
`timescale 1ns / 1ps

package deq_pkg;

  localparam int unsigned KIND_W   = 3;
  localparam int unsigned WORD_W   = 64;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned FILL_W   = 11;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_BACK  = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_POP_BACK   = 3'd3,
    KIND_PEEK_FRONT = 3'd4,
    KIND_PEEK_BACK  = 3'd5,
    KIND_CLEAR      = 3'd6
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_VALUE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  // what a request leaves for the response stage besides the read data
  typedef struct packed {
    status_t             status;
    logic [FILL_W-1:0]   fill_count;
  } rsp_info_t;

endpackage

>>> hdl/deq_if.sv
`timescale 1ns / 1ps

interface deq_req_if;
  logic                                valid;
  logic                                ready;
  logic        [deq_pkg::KIND_W-1:0]   kind;
  logic signed [deq_pkg::WORD_W-1:0]   push_value;

  modport source (output valid, output kind, output push_value, input ready);
  modport sink   (input valid, input kind, input push_value, output ready);
endinterface

interface deq_rsp_if;
  logic                                valid;
  logic                                ready;
  logic        [deq_pkg::STATUS_W-1:0] status;
  logic signed [deq_pkg::WORD_W-1:0]   result_value;
  logic        [deq_pkg::FILL_W-1:0]   fill_count;

  modport source (output valid, output status, output result_value, output fill_count,
                  input ready);
  modport sink   (input valid, input status, input result_value, input fill_count,
                  output ready);
endinterface

>>> hdl/double_ended_queue.sv
`timescale 1ns / 1ps

// bounded double-ended queue of signed 64-bit words held in one ring memory
// in_ch carries a request (kind, push_value), out_ch returns one response per
// request (status, result_value, fill_count), both valid/ready channels
// a request is taken when in_ch.valid and in_ch.ready are high at a clock edge
// its response passes the read stage (memory access, pointer update and
// registered memory read) and the output register, in that order, to out_ch
// throughput is one request per cycle unless out_ch stalls; the single memory port
// (one access per request, never a read and a write together) sets that figure
// pushes write the memory at once and later reads see them, so requests
// can follow each other with no bubbles
// when out_ch.ready is low the response holds in the output register, one more
// request may sit in the read stage, and in_ch.ready then drops until the
// output drains
// reset (rst_n low, synchronous) empties the queue and drops any response in
// flight; memory contents are not cleared since only written entries are read
module double_ended_queue #(
  parameter int unsigned DEPTH = 1024
) (
  input  logic           clk,
  input  logic           rst_n,
  deq_req_if.sink        in_ch,
  deq_rsp_if.source      out_ch
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic                               req_fire;
  logic                               out_free;
  logic                               advance;
  logic                               mem_we;
  logic                               mem_re;
  logic [AW-1:0]                      mem_addr;
  logic [deq_pkg::WORD_W-1:0]         mem_wdata;
  logic [deq_pkg::WORD_W-1:0]         mem_rdata;
  deq_pkg::rsp_info_t                 info;

  logic                               p_vld_r, p_vld_nxt;
  deq_pkg::rsp_info_t                 p_info_r;
  logic                               out_vld_r, out_vld_nxt;
  deq_pkg::rsp_info_t                 out_info_r;
  logic [deq_pkg::WORD_W-1:0]         out_value_r;

  assign out_free     = !out_vld_r || out_ch.ready;
  assign advance      = p_vld_r && out_free;
  assign in_ch.ready  = !p_vld_r || out_free;
  assign req_fire     = in_ch.valid && in_ch.ready;

  deq_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_fire   (req_fire),
    .kind       (in_ch.kind),
    .push_value (in_ch.push_value),
    .mem_we     (mem_we),
    .mem_re     (mem_re),
    .mem_addr   (mem_addr),
    .mem_wdata  (mem_wdata),
    .info       (info)
  );

  deq_ram #(
    .WIDTH (deq_pkg::WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_addr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_addr),
    .rdata (mem_rdata)
  );

  always_comb begin
    p_vld_nxt = p_vld_r;
    if (req_fire) begin
      p_vld_nxt = 1'b1;
    end else if (advance) begin
      p_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_vld_r;
    if (advance) begin
      out_vld_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      p_vld_r   <= p_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // read data stays in the memory output register until the stage advances
  always_ff @(posedge clk) begin
    if (req_fire) begin
      p_info_r <= info;
    end
    if (advance) begin
      out_info_r  <= p_info_r;
      out_value_r <= (p_info_r.status == deq_pkg::ST_VALUE) ? mem_rdata : '0;
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.status       = out_info_r.status;
  assign out_ch.result_value = out_value_r;
  assign out_ch.fill_count   = out_info_r.fill_count;

endmodule

>>> hdl/deq_ram.sv
`timescale 1ns / 1ps

module deq_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/deq_ctrl.sv
`timescale 1ns / 1ps

module deq_ctrl #(
  parameter int unsigned DEPTH = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                req_fire,
  input  logic [deq_pkg::KIND_W-1:0]          kind,
  input  logic [deq_pkg::WORD_W-1:0]          push_value,
  output logic                                mem_we,
  output logic                                mem_re,
  output logic [$clog2(DEPTH)-1:0]            mem_addr,
  output logic [deq_pkg::WORD_W-1:0]          mem_wdata,
  output deq_pkg::rsp_info_t                  info
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = AW + 1;
  localparam int unsigned FILL_PAD = deq_pkg::FILL_W - 1;

  logic [AW-1:0]        head_r, head_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic                 is_empty, is_full;
  logic [AW-1:0]        head_dec, head_inc;
  logic [SW-1:0]        tail_sum, last_sum;
  logic [AW-1:0]        tail_pos, last_pos;
  logic [CW+FILL_PAD:0] fill_ext;
  deq_pkg::status_t     status;

  assign is_empty = (cnt_r == '0);
  assign is_full  = (cnt_r == CW'(DEPTH));

  // ring neighbors of the head
  assign head_dec = (head_r == '0) ? AW'(DEPTH - 1) : head_r - AW'(1);
  assign head_inc = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + AW'(1);

  // free slot after the back and the back element itself
  assign tail_sum = SW'(head_r) + SW'(cnt_r);
  assign last_sum = SW'(head_r) + SW'(cnt_r) - SW'(1);
  assign tail_pos = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH)) : AW'(tail_sum);
  assign last_pos = (last_sum >= SW'(DEPTH)) ? AW'(last_sum - SW'(DEPTH)) : AW'(last_sum);

  always_comb begin
    head_nxt  = head_r;
    cnt_nxt   = cnt_r;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = head_r;
    mem_wdata = push_value;
    status    = deq_pkg::ST_OK;
    unique case (deq_pkg::kind_t'(kind))
      deq_pkg::KIND_PUSH_FRONT: begin
        if (is_full) begin
          status = deq_pkg::ST_FULL;
        end else begin
          head_nxt = head_dec;
          cnt_nxt  = cnt_r + CW'(1);
          mem_we   = req_fire;
          mem_addr = head_dec;
        end
      end
      deq_pkg::KIND_PUSH_BACK: begin
        if (is_full) begin
          status = deq_pkg::ST_FULL;
        end else begin
          cnt_nxt  = cnt_r + CW'(1);
          mem_we   = req_fire;
          mem_addr = tail_pos;
        end
      end
      deq_pkg::KIND_POP_FRONT, deq_pkg::KIND_PEEK_FRONT: begin
        if (is_empty) begin
          status = deq_pkg::ST_EMPTY;
        end else begin
          status   = deq_pkg::ST_VALUE;
          mem_re   = req_fire;
          mem_addr = head_r;
          if (kind == deq_pkg::KIND_POP_FRONT) begin
            head_nxt = head_inc;
            cnt_nxt  = cnt_r - CW'(1);
          end
        end
      end
      deq_pkg::KIND_POP_BACK, deq_pkg::KIND_PEEK_BACK: begin
        if (is_empty) begin
          status = deq_pkg::ST_EMPTY;
        end else begin
          status   = deq_pkg::ST_VALUE;
          mem_re   = req_fire;
          mem_addr = last_pos;
          if (kind == deq_pkg::KIND_POP_BACK) begin
            cnt_nxt = cnt_r - CW'(1);
          end
        end
      end
      deq_pkg::KIND_CLEAR: begin
        head_nxt = '0;
        cnt_nxt  = '0;
      end
      default: begin
        // unused code leaves everything alone
      end
    endcase
  end

  // count after the request, low bits only
  assign fill_ext        = {{deq_pkg::FILL_W{1'b0}}, cnt_nxt};
  assign info.status     = status;
  assign info.fill_count = fill_ext[deq_pkg::FILL_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      cnt_r  <= '0;
    end else if (req_fire) begin
      head_r <= head_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

>>> tb/sv/double_ended_queue_tb.sv
`timescale 1ns / 1ps

module double_ended_queue_tb;

  localparam int unsigned QDEPTH      = 1024;
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned ITEM_TARGET = 1800;

  // kind 7 carries no meaning and must leave the queue untouched
  localparam logic [deq_pkg::KIND_W-1:0] KIND_UNUSED = 3'd7;

  localparam int MIX_BALANCED  = 0;
  localparam int MIX_PUSH_HEAVY = 1;
  localparam int MIX_POP_HEAVY  = 2;

  typedef struct {
    logic [deq_pkg::KIND_W-1:0]        kind;
    logic signed [deq_pkg::WORD_W-1:0] word;
    bit                                wait_drain;
  } deque_req_t;

  typedef struct {
    deq_pkg::status_t                  status;
    logic signed [deq_pkg::WORD_W-1:0] value;
    logic [deq_pkg::FILL_W-1:0]        fill;
  } deque_rsp_t;

  logic clk = 1'b0;
  logic rst_n;

  deq_req_if req_bus ();
  deq_rsp_if rsp_bus ();

  double_ended_queue #(
    .DEPTH (QDEPTH)
  ) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_bus),
    .out_ch (rsp_bus)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  deque_req_t pending_requests[$];
  deque_rsp_t awaited_responses[$];

  // mirror of the queue contents
  logic signed [deq_pkg::WORD_W-1:0] mirror_store [QDEPTH];
  int unsigned mirror_head;
  int unsigned mirror_count;

  int  mismatches;
  bit  req_fire;
  bit  rsp_fire;
  int  tx_wait;
  int  tx_sent;
  bit  tx_busy_phase;
  int  rx_wait;
  int  rx_seen;
  bit  rx_busy_phase;
  int  idle_cycles;

  task automatic deque_apply(input logic [deq_pkg::KIND_W-1:0] kind,
                             input logic signed [deq_pkg::WORD_W-1:0] word);
    deque_rsp_t rsp;
    int unsigned slot;
    rsp.status = deq_pkg::ST_OK;
    rsp.value  = '0;
    case (kind)
      deq_pkg::KIND_PUSH_FRONT, deq_pkg::KIND_PUSH_BACK: begin
        if (mirror_count >= QDEPTH) begin
          rsp.status = deq_pkg::ST_FULL;
        end else if (kind == deq_pkg::KIND_PUSH_FRONT) begin
          mirror_head = (mirror_head + QDEPTH - 1) % QDEPTH;
          mirror_store[mirror_head] = word;
          mirror_count++;
        end else begin
          mirror_store[(mirror_head + mirror_count) % QDEPTH] = word;
          mirror_count++;
        end
      end
      deq_pkg::KIND_POP_FRONT, deq_pkg::KIND_PEEK_FRONT: begin
        if (mirror_count == 0) begin
          rsp.status = deq_pkg::ST_EMPTY;
        end else begin
          rsp.status = deq_pkg::ST_VALUE;
          rsp.value  = mirror_store[mirror_head];
          if (kind == deq_pkg::KIND_POP_FRONT) begin
            mirror_head = (mirror_head + 1) % QDEPTH;
            mirror_count--;
          end
        end
      end
      deq_pkg::KIND_POP_BACK, deq_pkg::KIND_PEEK_BACK: begin
        if (mirror_count == 0) begin
          rsp.status = deq_pkg::ST_EMPTY;
        end else begin
          slot = (mirror_head + mirror_count - 1) % QDEPTH;
          rsp.status = deq_pkg::ST_VALUE;
          rsp.value  = mirror_store[slot];
          if (kind == deq_pkg::KIND_POP_BACK) begin
            mirror_count--;
          end
        end
      end
      deq_pkg::KIND_CLEAR: begin
        mirror_count = 0;
        mirror_head  = 0;
      end
      default: begin
      end
    endcase
    rsp.fill = deq_pkg::FILL_W'(mirror_count);
    awaited_responses.insert(awaited_responses.size(), rsp);
  endtask

  task automatic add_request(input logic [deq_pkg::KIND_W-1:0] kind,
                             input logic signed [deq_pkg::WORD_W-1:0] word,
                             input bit wait_drain = 1'b0);
    deque_req_t r;
    r.kind       = kind;
    r.word       = word;
    r.wait_drain = wait_drain;
    pending_requests.insert(pending_requests.size(), r);
  endtask

  function automatic logic signed [deq_pkg::WORD_W-1:0] rand_word();
    case ($urandom_range(0, 15))
      0: rand_word = {1'b0, {(deq_pkg::WORD_W-1){1'b1}}};
      1: rand_word = {1'b1, {(deq_pkg::WORD_W-1){1'b0}}};
      2: rand_word = '0;
      3: rand_word = '1;
      default: rand_word = {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [deq_pkg::KIND_W-1:0] rand_kind(input int mix);
    int unsigned r;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_PUSH_HEAVY: rand_kind = (r < 70) ? deq_pkg::KIND_W'($urandom_range(0, 1))
                                           : deq_pkg::KIND_W'($urandom_range(2, 5));
      MIX_POP_HEAVY:  rand_kind = (r < 25) ? deq_pkg::KIND_W'($urandom_range(0, 1))
                                           : deq_pkg::KIND_W'($urandom_range(2, 5));
      default: begin
        if (r < 2) rand_kind = KIND_UNUSED;
        else if (r < 5) rand_kind = deq_pkg::KIND_CLEAR;
        else rand_kind = deq_pkg::KIND_W'($urandom_range(0, 5));
      end
    endcase
  endfunction

  // request driver
  always @(negedge clk) begin : drive_requests
    deque_req_t next_req;
    if (!rst_n) begin
      req_bus.valid <= 1'b0;
    end else if (req_fire || !req_bus.valid) begin
      if (tx_wait > 0) begin
        req_bus.valid <= 1'b0;
        tx_wait--;
      end else if (pending_requests.size() != 0 &&
                   !(pending_requests[0].wait_drain && awaited_responses.size() != 0)) begin
        next_req = pending_requests[0];
        pending_requests.delete(0);
        req_bus.valid      <= 1'b1;
        req_bus.kind       <= next_req.kind;
        req_bus.push_value <= next_req.word;
        tx_sent++;
        if (tx_sent % 128 == 0) tx_busy_phase = !tx_busy_phase;
        tx_wait = tx_busy_phase ? $urandom_range(0, 7) : 0;
      end else begin
        req_bus.valid <= 1'b0;
      end
    end
  end

  // response receiver, with a couple of long holds to back the queue up
  always @(negedge clk) begin
    if (!rst_n) begin
      rsp_bus.ready <= 1'b0;
    end else begin
      if (rsp_fire) begin
        rx_seen++;
        if (rx_seen % 150 == 0) rx_busy_phase = !rx_busy_phase;
        if (rx_seen == 100 || rx_seen == 1300) rx_wait = LONG_HOLD;
        else rx_wait = rx_busy_phase ? $urandom_range(0, 7) : 0;
      end
      if (rx_wait > 0) begin
        rsp_bus.ready <= 1'b0;
        rx_wait--;
      end else begin
        rsp_bus.ready <= 1'b1;
      end
    end
  end

  // predict on each accepted request, then check each accepted response
  always @(posedge clk) begin : watch_channels
    deque_rsp_t want;
    req_fire <= rst_n && req_bus.valid && req_bus.ready;
    rsp_fire <= rst_n && rsp_bus.valid && rsp_bus.ready;
    if (rst_n && req_bus.valid && req_bus.ready) begin
      deque_apply(req_bus.kind, req_bus.push_value);
    end
    if (rst_n && rsp_bus.valid && rsp_bus.ready) begin
      if (awaited_responses.size() == 0) begin
        $error("response with no request outstanding");
        mismatches++;
      end else begin
        want = awaited_responses[0];
        awaited_responses.delete(0);
        if (rsp_bus.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp_bus.status);
          mismatches++;
        end
        if (rsp_bus.result_value !== want.value) begin
          $error("result_value: expected %0d, got %0d", want.value, rsp_bus.result_value);
          mismatches++;
        end
        if (rsp_bus.fill_count !== want.fill) begin
          $error("fill_count: expected %0d, got %0d", want.fill, rsp_bus.fill_count);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && !(req_bus.valid && req_bus.ready) && !(rsp_bus.valid && rsp_bus.ready)) begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $error("no request or response moved for %0d cycles", STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end else begin
      idle_cycles = 0;
    end
  end

  initial begin
    int mix;
    int seg_left;
    int unsigned pushes;

    rst_n              = 1'b0;
    req_bus.valid      = 1'b0;
    req_bus.kind       = deq_pkg::KIND_PUSH_FRONT;
    req_bus.push_value = '0;
    rsp_bus.ready      = 1'b0;
    mirror_head        = 0;
    mirror_count       = 0;

    // empty errors, the meaningless kind, extreme words, both ends
    add_request(deq_pkg::KIND_POP_FRONT, '0);
    add_request(deq_pkg::KIND_POP_BACK, '0);
    add_request(deq_pkg::KIND_PEEK_FRONT, '0);
    add_request(deq_pkg::KIND_PEEK_BACK, '0);
    add_request(KIND_UNUSED, '1);
    add_request(deq_pkg::KIND_PUSH_FRONT, {1'b0, {(deq_pkg::WORD_W-1){1'b1}}});
    add_request(deq_pkg::KIND_PUSH_BACK, {1'b1, {(deq_pkg::WORD_W-1){1'b0}}});
    add_request(deq_pkg::KIND_PUSH_FRONT, '1);
    add_request(deq_pkg::KIND_PUSH_BACK, '0);
    add_request(deq_pkg::KIND_PUSH_FRONT, {(deq_pkg::WORD_W/2){2'b01}});
    add_request(KIND_UNUSED, {$urandom, $urandom});
    add_request(deq_pkg::KIND_PEEK_FRONT, '0);
    add_request(deq_pkg::KIND_PEEK_BACK, '0);
    add_request(deq_pkg::KIND_POP_BACK, '0);
    add_request(deq_pkg::KIND_POP_FRONT, '0);
    add_request(deq_pkg::KIND_CLEAR, '0);
    add_request(deq_pkg::KIND_PEEK_FRONT, '0);
    add_request(deq_pkg::KIND_PUSH_BACK, {(deq_pkg::WORD_W/2){2'b10}});
    add_request(deq_pkg::KIND_PUSH_FRONT, 64'sd1);
    add_request(deq_pkg::KIND_POP_FRONT, '0);
    add_request(deq_pkg::KIND_POP_BACK, '0);
    add_request(deq_pkg::KIND_POP_BACK, '0);
    add_request(deq_pkg::KIND_PUSH_BACK, 64'sd5);
    add_request(deq_pkg::KIND_CLEAR, '0);

    // fill to the brim with some peeks mixed in, then hit the full error on both ends
    pushes = 0;
    while (pushes < QDEPTH + 4) begin
      if ($urandom_range(0, 9) == 0) begin
        add_request(deq_pkg::KIND_W'($urandom_range(4, 5)), rand_word(), pushes == 0);
      end else begin
        add_request(deq_pkg::KIND_W'($urandom_range(0, 1)), rand_word(), pushes == 0);
        pushes++;
      end
    end
    add_request(deq_pkg::KIND_PUSH_FRONT, rand_word());
    add_request(deq_pkg::KIND_PUSH_BACK, rand_word());

    // drain mostly, then mixed segments until the item count is reached
    for (int i = 0; i < 300; i++) add_request(rand_kind(MIX_POP_HEAVY), rand_word());
    add_request(deq_pkg::KIND_CLEAR, '0, 1'b1);
    while (pending_requests.size() < ITEM_TARGET) begin
      mix = $urandom_range(MIX_BALANCED, MIX_POP_HEAVY);
      seg_left = $urandom_range(40, 80);
      repeat (seg_left) add_request(rand_kind(mix), rand_word());
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_requests.size() != 0 || req_bus.valid) @(posedge clk);
    while (awaited_responses.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);

    if (mismatches == 0 && awaited_responses.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
